### src/cfr_pkg.sv
// Shared types and constants for the checksummed frame receiver.
package cfr_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned DistW   = 16;
  localparam int unsigned NumPay  = 5;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] CFG_START_BYTE = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_END_BYTE   = 1'b1;

  localparam logic [ByteW-1:0] START_BYTE_RST = 8'hA0;
  localparam logic [ByteW-1:0] END_BYTE_RST   = 8'h0A;

  typedef enum logic [2:0] {
    POS_HUNT  = 3'd0,
    POS_PAY0  = 3'd1,
    POS_PAY1  = 3'd2,
    POS_PAY2  = 3'd3,
    POS_PAY3  = 3'd4,
    POS_PAY4  = 3'd5,
    POS_CHECK = 3'd6,
    POS_END   = 3'd7
  } frame_pos_t;

  typedef struct packed {
    logic [ByteW-1:0] angle_direction;
    logic [ByteW-1:0] angle_magnitude;
    logic [DistW-1:0] distance;
    logic [ByteW-1:0] found_state;
  } frame_res_t;

endpackage

### src/cfr_in_if.sv
// Input byte channel: valid/ready handshake with one received byte.
interface cfr_in_if import cfr_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

### src/cfr_out_if.sv
// Result channel: valid/ready handshake with the unpacked frame fields.
interface cfr_out_if import cfr_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] angle_direction;
  logic [ByteW-1:0] angle_magnitude;
  logic [DistW-1:0] distance;
  logic [ByteW-1:0] found_state;

  modport source (output valid, output angle_direction, output angle_magnitude,
                  output distance, output found_state, input ready);
  modport sink   (input valid, input angle_direction, input angle_magnitude,
                  input distance, input found_state, output ready);
endinterface

### src/checksummed_frame_receiver_unit.sv
// Frame receiver top level: start hunt, payload capture, checksum and end check.
//
//   channel  | dir | payload                                          | handshake
//   in_ch    | in  | rx_byte[7:0]                                     | valid/ready
//   out_ch   | out | angle_direction, angle_magnitude, distance[15:0], | valid/ready
//            |     | found_state                                      |
//   cfg_*    | in  | cfg_index[0], cfg_data[7:0]                      | cfg_we
//
// One byte is taken per cycle while in_ch.ready is high; the frame state advances in the same cycle and a
// good frame's result is registered, shown the cycle after its end byte unless it waits in the skid entry.
// A result register plus one skid entry hold results; input stalls only while
// the skid entry is full. Reset (synchronous, rst_n low) returns the parser to
// hunting and restores start byte 0xA0 and end byte 0x0A.
module checksummed_frame_receiver_unit import cfr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  cfr_in_if.sink             in_ch,
  cfr_out_if.source          out_ch,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [ByteW-1:0]   cfg_data
);

  logic [ByteW-1:0] start_byte_r;
  logic [ByteW-1:0] end_byte_r;
  frame_pos_t       pos_r, pos_nxt;
  logic [ByteW-1:0] sum_r, sum_nxt;
  logic [ByteW-1:0] pay_r [NumPay];

  frame_res_t       out_r, skid_r, res;
  logic             out_valid_r, skid_valid_r;
  logic             in_fire, out_fire, res_fire;

  assign in_ch.ready = !skid_valid_r;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_valid_r && out_ch.ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= START_BYTE_RST;
      end_byte_r   <= END_BYTE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_BYTE: start_byte_r <= cfg_data;
        CFG_END_BYTE:   end_byte_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // frame position, running sum and result detect
  always_comb begin
    pos_nxt  = pos_r;
    sum_nxt  = sum_r;
    res_fire = 1'b0;
    if (in_fire) begin
      unique case (pos_r) inside
        POS_HUNT: begin
          if (in_ch.rx_byte == start_byte_r) begin
            sum_nxt = '0;
            pos_nxt = POS_PAY0;
          end
        end
        POS_PAY0, POS_PAY1, POS_PAY2, POS_PAY3, POS_PAY4: begin
          sum_nxt = sum_r + in_ch.rx_byte;
          pos_nxt = frame_pos_t'(pos_r + 3'd1);
        end
        POS_CHECK: begin
          pos_nxt = (in_ch.rx_byte == sum_r) ? POS_END : POS_HUNT;
        end
        POS_END: begin
          pos_nxt  = POS_HUNT;
          res_fire = (in_ch.rx_byte == end_byte_r);
        end
        default: pos_nxt = POS_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_HUNT;
      sum_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
    end
  end

  // capture payload bytes at their own slots
  always_ff @(posedge clk) begin
    if (in_fire) begin
      case (pos_r)
        POS_PAY0: pay_r[0] <= in_ch.rx_byte;
        POS_PAY1: pay_r[1] <= in_ch.rx_byte;
        POS_PAY2: pay_r[2] <= in_ch.rx_byte;
        POS_PAY3: pay_r[3] <= in_ch.rx_byte;
        POS_PAY4: pay_r[4] <= in_ch.rx_byte;
        default: ;
      endcase
    end
  end

  always_comb begin
    res.angle_direction = pay_r[0];
    res.angle_magnitude = pay_r[1];
    res.distance        = {pay_r[3], pay_r[2]};
    res.found_state     = pay_r[4];
  end

  // result register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (res_fire) begin
      if (out_valid_r && !out_ch.ready) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_r <= skid_r;
      end
    end else if (res_fire) begin
      if (out_valid_r && !out_ch.ready) begin
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.angle_direction = out_r.angle_direction;
  assign out_ch.angle_magnitude = out_r.angle_magnitude;
  assign out_ch.distance        = out_r.distance;
  assign out_ch.found_state     = out_r.found_state;

endmodule

### bench/tb_checksummed_frame_receiver_unit.sv
// Testbench for the checksummed frame receiver: directed and random frames, checked in order.
module tb_checksummed_frame_receiver_unit import cfr_pkg::*;;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned HoldOffLen = 200;
  localparam int unsigned PhaseItems = 110;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [ByteW-1:0] cfg_data;

  cfr_in_if  in_ch ();
  cfr_out_if out_ch ();

  checksummed_frame_receiver_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Frame tracker: mirrors the parser state and queues the frames it should report.
  frame_pos_t       parse_pos;
  logic [ByteW-1:0] frame_bytes [NumPay];
  logic [ByteW-1:0] frame_sum;
  logic [ByteW-1:0] start_code;
  logic [ByteW-1:0] end_code;
  frame_res_t       expected_frames [$];

  int unsigned fail_count;
  int unsigned sent_items;
  int unsigned hold_off_len;
  bit          src_gaps_on;
  bit          sink_gaps_on;

  function automatic void track_byte(logic [ByteW-1:0] b);
    frame_res_t fr;
    case (parse_pos) inside
      POS_HUNT: begin
        if (b == start_code) begin
          frame_sum = '0;
          parse_pos = POS_PAY0;
        end
      end
      POS_PAY0, POS_PAY1, POS_PAY2, POS_PAY3, POS_PAY4: begin
        frame_bytes[parse_pos - 3'd1] = b;
        frame_sum += b;
        parse_pos = frame_pos_t'(parse_pos + 3'd1);
      end
      POS_CHECK: begin
        parse_pos = (b == frame_sum) ? POS_END : POS_HUNT;
      end
      default: begin
        parse_pos = POS_HUNT;
        if (b == end_code) begin
          fr.angle_direction = frame_bytes[0];
          fr.angle_magnitude = frame_bytes[1];
          fr.distance        = {frame_bytes[3], frame_bytes[2]};
          fr.found_state     = frame_bytes[4];
          expected_frames.push_back(fr);
        end
      end
    endcase
  endfunction

  function automatic void flag_error(string what);
    fail_count++;
    if (fail_count <= 10) $display("ERROR: %s", what);
  endfunction

  task automatic send_byte(input logic [ByteW-1:0] b);
    if (src_gaps_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    track_byte(b);
    sent_items++;
  endtask

  // Drop valid and wait until every queued frame has come out and the parser has settled.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_codes(input logic [ByteW-1:0] s, input logic [ByteW-1:0] e);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_START_BYTE;
    cfg_data  <= s;
    @(posedge clk);
    cfg_index <= CFG_END_BYTE;
    cfg_data  <= e;
    @(posedge clk);
    cfg_we    <= 1'b0;
    start_code = s;
    end_code   = e;
  endtask

  function automatic logic [ByteW-1:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return start_code;
      3: return end_code;
      default: return ByteW'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_frame(input bit bad_sum, input bit bad_end);
    logic [ByteW-1:0] b;
    logic [ByteW-1:0] sum;
    sum = '0;
    send_byte(start_code);
    repeat (NumPay) begin
      b = pick_byte();
      sum += b;
      send_byte(b);
    end
    send_byte(bad_sum ? sum ^ ByteW'(1 << $urandom_range(0, 7)) : sum);
    send_byte(bad_end ? end_code ^ ByteW'($urandom_range(1, 255)) : end_code);
  endtask

  task automatic send_list(input logic [ByteW-1:0] bytes [$]);
    foreach (bytes[k]) send_byte(bytes[k]);
  endtask

  // Mostly good frames, some with a broken checksum or trailer, with stray bytes between.
  task automatic run_phase(input logic [ByteW-1:0] s, input logic [ByteW-1:0] e,
                           input int unsigned n_items);
    int unsigned first;
    int unsigned kind;
    settle();
    set_codes(s, e);
    first = sent_items;
    while (sent_items - first < n_items) begin
      repeat ($urandom_range(0, 2)) send_byte(ByteW'($urandom_range(0, 255)));
      kind = $urandom_range(0, 9);
      send_frame(kind == 8, kind == 9);
    end
  endtask

  task automatic test_directed_frames();
    // extremes, with the start value inside the payload
    send_list('{8'hA0, 8'hFF, 8'hA0, 8'h00, 8'hFF, 8'h00, 8'h9E, 8'h0A});
    // checksum mismatch
    send_list('{8'hA0, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h00});
    // wrong trailer equal to the start value: must not open a frame
    send_list('{8'hA0, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h0F, 8'hA0});
    send_list('{8'h10, 8'h20, 8'h30, 8'h40, 8'h50, 8'hF0, 8'h0A});
  endtask

  task automatic test_code_sweep();
    run_phase(8'h00, 8'hFF, PhaseItems);
    run_phase(8'hFF, 8'h00, PhaseItems);
    run_phase(8'h5A, 8'h5A, PhaseItems);
    run_phase(ByteW'($urandom_range(0, 255)), ByteW'($urandom_range(0, 255)), PhaseItems);
  endtask

  task automatic test_output_backpressure();
    settle();
    src_gaps_on  = 1'b0;
    hold_off_len = HoldOffLen;
    repeat (8) send_frame(1'b0, 1'b0);
    src_gaps_on  = 1'b1;
  endtask

  task automatic test_full_rate();
    settle();
    src_gaps_on  = 1'b0;
    sink_gaps_on = 1'b0;
    run_phase(START_BYTE_RST, END_BYTE_RST, PhaseItems);
  endtask

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      @(posedge clk);
      if (hold_off_len != 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_off_len) @(posedge clk);
        hold_off_len = 0;
        out_ch.ready <= 1'b1;
      end else if (sink_gaps_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    frame_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_frames.size() == 0) begin
        flag_error($sformatf("unexpected frame dir=%0h mag=%0h dist=%0h found=%0h",
                             out_ch.angle_direction, out_ch.angle_magnitude,
                             out_ch.distance, out_ch.found_state));
      end else begin
        want = expected_frames.pop_front();
        if (out_ch.angle_direction !== want.angle_direction)
          flag_error($sformatf("angle_direction exp %0h got %0h",
                               want.angle_direction, out_ch.angle_direction));
        if (out_ch.angle_magnitude !== want.angle_magnitude)
          flag_error($sformatf("angle_magnitude exp %0h got %0h",
                               want.angle_magnitude, out_ch.angle_magnitude));
        if (out_ch.distance !== want.distance)
          flag_error($sformatf("distance exp %0h got %0h", want.distance, out_ch.distance));
        if (out_ch.found_state !== want.found_state)
          flag_error($sformatf("found_state exp %0h got %0h",
                               want.found_state, out_ch.found_state));
      end
    end
  end

  // Abort when nothing moves on either channel for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("checksummed_frame_receiver_unit regression: fail");
    $finish;
  end

  initial begin
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_START_BYTE;
    cfg_data      <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= '0;
    parse_pos     = POS_HUNT;
    frame_sum     = '0;
    start_code    = START_BYTE_RST;
    end_code      = END_BYTE_RST;
    fail_count    = 0;
    sent_items    = 0;
    hold_off_len  = 0;
    src_gaps_on   = 1'b1;
    sink_gaps_on  = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_frames();
    test_code_sweep();
    test_output_backpressure();
    test_full_rate();

    settle();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && expected_frames.size() == 0) begin
      $display("checksummed_frame_receiver_unit regression: pass");
    end else begin
      $display("checksummed_frame_receiver_unit regression: fail");
    end
    $finish;
  end

endmodule
